### sv/tpm_pkg.sv
// ---------------------------------------------------------------------------
// tpm_pkg
// Shared types and codes for the texture pool matcher: command and status
// codes, field widths and the request item passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

   // default pool size
   localparam int POOL_DEPTH_DEF = 16;

   // field widths
   localparam int CMD_W    = 2;
   localparam int FORMAT_W = 8;
   localparam int DIM_W    = 15;
   localparam int USAGE_W  = 16;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

   // classified request waiting in the queue
   typedef struct packed {
      logic [CMD_W-1:0]    op;
      logic [FORMAT_W-1:0] format;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [USAGE_W-1:0]  usage;
      logic [HANDLE_W-1:0] handle;   // new handle on acquire, lookup handle on release
   } req_item_type;

endpackage

`default_nettype wire

### sv/texture_pool_matcher.sv
// ---------------------------------------------------------------------------
// texture_pool_matcher
// Pool of texture handles with first-fit reuse.
//
// Request channel (req_*): command 0 acquires a texture matching format,
// width, height and usage, reusing the first idle match or appending
// new_handle; command 1 releases handle_in; command 2 flushes the pool;
// command 3 is accepted and dropped without a response.
// Response channel (rsp_*): one response per acquire or release, one per
// stored entry on flush (a single empty-pool response if nothing is stored),
// rsp_last marks the final response of each request.
// A request is held in the request queue, then its response is registered.
// Throughput: one acquire or release per cycle unless rsp_stall holds the
// response, using a parallel compare over all entries; a flush holds the
// pool until each stored entry is read, one handle a cycle if not stalled.
// A two-entry request queue decouples the request side from the pool, and
// the pool takes a new request in the same cycle the previous response is
// taken. While a response waits under rsp_stall the pool holds and the queue
// fills, then req_stall rises. Reset empties the pool and both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module texture_pool_matcher
   import tpm_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [FORMAT_W-1:0] req_tex_format,
   input  wire logic [DIM_W-1:0]    req_tex_width,
   input  wire logic [DIM_W-1:0]    req_tex_height,
   input  wire logic [USAGE_W-1:0]  req_usage_flags,
   input  wire logic [HANDLE_W-1:0] req_new_handle,
   input  wire logic [HANDLE_W-1:0] req_handle_in,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [HANDLE_W-1:0] rsp_handle_out,
   output      logic                rsp_reused,
   output      logic                rsp_created,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_last
);

   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;

   // request front end and queue
   tpm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_tex_format  (req_tex_format),
      .req_tex_width   (req_tex_width),
      .req_tex_height  (req_tex_height),
      .req_usage_flags (req_usage_flags),
      .req_new_handle  (req_new_handle),
      .req_handle_in   (req_handle_in),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   // pool and response
   tpm_back #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_handle_out (rsp_handle_out),
      .rsp_reused     (rsp_reused),
      .rsp_created    (rsp_created),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

### sv/tpm_front.sv
// ---------------------------------------------------------------------------
// tpm_front
// Request front end: accepts requests, drops the unused command, picks the
// handle that matters for the command and holds items in a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tpm_front
   import tpm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [FORMAT_W-1:0] req_tex_format,
   input  wire logic [DIM_W-1:0]    req_tex_width,
   input  wire logic [DIM_W-1:0]    req_tex_height,
   input  wire logic [USAGE_W-1:0]  req_usage_flags,
   input  wire logic [HANDLE_W-1:0] req_new_handle,
   input  wire logic [HANDLE_W-1:0] req_handle_in,
   output      logic                q_valid,
   output      req_item_type        q_item,
   input  wire logic                q_pop
);

   req_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   q_count_ff, q_count_in;
   logic         push;
   logic         pop;
   req_item_type item;

   // classify the incoming request
   always_comb begin
      item.op     = req_command;
      item.format = req_tex_format;
      item.width  = req_tex_width;
      item.height = req_tex_height;
      item.usage  = req_usage_flags;
      item.handle = (req_command == CMD_RELEASE) ? req_handle_in : req_new_handle;
   end

   // queue control
   assign req_stall = (q_count_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_command != CMD_UNUSED);
   assign q_valid   = (q_count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      q_count_in = q_count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         q_count_ff <= 2'd0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

### sv/tpm_back.sv
// ---------------------------------------------------------------------------
// tpm_back
// Pool execution: holds the entries, matches acquire and release against all
// entries at once with first-match priority, walks the pool one entry a cycle
// on flush unless rsp_stall holds it, and drives the registered response.
// ---------------------------------------------------------------------------
`default_nettype none

module tpm_back
   import tpm_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire req_item_type        q_item,
   output      logic                q_pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [HANDLE_W-1:0] rsp_handle_out,
   output      logic                rsp_reused,
   output      logic                rsp_created,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_last
);

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam logic [POOL_DEPTH-1:0] ONE = POOL_DEPTH'(1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_DEPTH);

   // entry storage
   logic [POOL_DEPTH-1:0] valid_ff, valid_in;
   logic [POOL_DEPTH-1:0] busy_ff, busy_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         flush_idx_ff, flush_idx_in;
   logic [FORMAT_W-1:0]   fmt_ff    [POOL_DEPTH];
   logic [DIM_W-1:0]      wid_ff    [POOL_DEPTH];
   logic [DIM_W-1:0]      hgt_ff    [POOL_DEPTH];
   logic [USAGE_W-1:0]    use_ff    [POOL_DEPTH];
   logic [HANDLE_W-1:0]   handle_ff [POOL_DEPTH];

   // response register
   logic                rsp_valid_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_reused_ff, rsp_reused_in;
   logic                rsp_created_ff, rsp_created_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                  adv;
   logic                  fire;
   logic [POOL_DEPTH-1:0] acq_match, acq_first;
   logic [POOL_DEPTH-1:0] rel_match, rel_first;
   logic [POOL_DEPTH-1:0] flush_dec;
   logic [POOL_DEPTH-1:0] app_sel;
   logic [POOL_DEPTH-1:0] rd_sel;
   logic [POOL_DEPTH-1:0] app_we;
   logic [HANDLE_W-1:0]   rd_handle;
   logic                  pool_full;
   logic                  pool_empty;
   logic                  flush_last;
   logic [CW-1:0]         flush_nxt;

   // parallel compare lanes
   always_comb begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
         acq_match[i] = valid_ff[i] && !busy_ff[i] &&
                        (fmt_ff[i] == q_item.format) && (wid_ff[i] == q_item.width) &&
                        (hgt_ff[i] == q_item.height) && (use_ff[i] == q_item.usage);
         rel_match[i] = valid_ff[i] && (handle_ff[i] == q_item.handle);
         flush_dec[i] = (flush_idx_ff == IW'(i));
         app_sel[i]   = (count_ff == CW'(i));
      end
   end

   // first match wins: isolate the lowest set bit
   assign acq_first = acq_match & (~acq_match + ONE);
   assign rel_first = rel_match & (~rel_match + ONE);

   // single handle read port, shared by reuse and flush
   assign rd_sel = (q_item.op == CMD_FLUSH) ? flush_dec : acq_first;

   always_comb begin
      rd_handle = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         rd_handle = rd_handle | (handle_ff[i] & {HANDLE_W{rd_sel[i]}});
      end
   end

   // pool status
   assign pool_full  = (count_ff == FULL_COUNT);
   assign pool_empty = (count_ff == '0);
   assign flush_nxt  = CW'(flush_idx_ff) + CW'(1);
   assign flush_last = (flush_nxt == count_ff);

   // handshake with queue and response register
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign fire  = q_valid && adv;
   assign q_pop = fire && ((q_item.op != CMD_FLUSH) || pool_empty || flush_last);

   // command execution
   always_comb begin
      valid_in       = valid_ff;
      busy_in        = busy_ff;
      count_in       = count_ff;
      flush_idx_in   = flush_idx_ff;
      app_we         = '0;
      rsp_handle_in  = '0;
      rsp_reused_in  = 1'b0;
      rsp_created_in = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_last_in    = 1'b1;
      unique case (q_item.op)
         CMD_ACQUIRE: begin
            priority if (acq_match != '0) begin
               busy_in       = busy_ff | acq_first;
               rsp_handle_in = rd_handle;
               rsp_reused_in = 1'b1;
            end else if (pool_full) begin
               rsp_status_in = STAT_FULL;
            end else begin
               app_we         = app_sel;
               valid_in       = valid_ff | app_sel;
               busy_in        = busy_ff | app_sel;
               count_in       = count_ff + CW'(1);
               rsp_handle_in  = q_item.handle;
               rsp_created_in = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (rel_match != '0) begin
               busy_in = busy_ff & ~rel_first;
            end else begin
               rsp_status_in = STAT_NOT_FOUND;
            end
         end
         CMD_FLUSH: begin
            priority if (pool_empty) begin
               rsp_status_in = STAT_EMPTY;
            end else if (flush_last) begin
               rsp_handle_in = rd_handle;
               valid_in      = '0;
               busy_in       = '0;
               count_in      = '0;
               flush_idx_in  = '0;
            end else begin
               rsp_handle_in = rd_handle;
               rsp_last_in   = 1'b0;
               flush_idx_in  = flush_idx_ff + IW'(1);
            end
         end
         default: begin
            rsp_status_in = STAT_OK;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         busy_ff      <= '0;
         count_ff     <= '0;
         flush_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            valid_ff     <= valid_in;
            busy_ff      <= busy_in;
            count_ff     <= count_in;
            flush_idx_ff <= flush_idx_in;
         end
         if (adv) begin
            rsp_valid_ff <= q_valid;
         end
      end
   end

   // entry payload, written on append
   always_ff @(posedge clock) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
         if (fire && app_we[i]) begin
            fmt_ff[i]    <= q_item.format;
            wid_ff[i]    <= q_item.width;
            hgt_ff[i]    <= q_item.height;
            use_ff[i]    <= q_item.usage;
            handle_ff[i] <= q_item.handle;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_handle_ff  <= rsp_handle_in;
         rsp_reused_ff  <= rsp_reused_in;
         rsp_created_ff <= rsp_created_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_reused     = rsp_reused_ff;
   assign rsp_created    = rsp_created_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
